### hdl/vpg_pkg.sv
// ----------------------------------------------------------------------------
// vpg_pkg
// Shared types, codes and the control store of the VAR process generator.
// ----------------------------------------------------------------------------
package vpg_pkg;

  // Default configuration
  localparam int unsigned DIM_DEF = 4;
  localparam int unsigned LAG_DEF = 4;

  // Fixed field widths
  localparam int unsigned NCH        = 4;   // channel ports on the interface
  localparam int unsigned DATA_W     = 16;
  localparam int unsigned SLOT_W     = 7;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  // Commands
  localparam logic [CMD_W-1:0] CMD_LOAD_COEF = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_HIST = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STEP      = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BURN_IN   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_CONST = 1'd1;

  // Fixed point: Q4.12 * Q8.8 -> Q.20
  localparam int unsigned FRAC_SH    = 12;
  localparam int          ROUND_HALF = 2048;
  localparam int          SAT_MAX    = 32767;
  localparam int          SAT_MIN    = -32768;
  localparam logic signed [DATA_W-1:0] ONE_Q8 = 16'sd256;

  // Microcode
  localparam int unsigned UPC_W = 3;
  localparam int unsigned UOP_W = 3;
  localparam int unsigned UCND_W = 2;

  localparam logic [UPC_W-1:0] UC_IDLE   = 3'd0;
  localparam logic [UPC_W-1:0] UC_INIT   = 3'd1;
  localparam logic [UPC_W-1:0] UC_MAC    = 3'd2;
  localparam logic [UPC_W-1:0] UC_CONST  = 3'd3;
  localparam logic [UPC_W-1:0] UC_DRAIN0 = 3'd4;
  localparam logic [UPC_W-1:0] UC_DRAIN1 = 3'd5;
  localparam logic [UPC_W-1:0] UC_FINISH = 3'd6;

  localparam logic [UOP_W-1:0] OP_NONE   = 3'd0;
  localparam logic [UOP_W-1:0] OP_INIT   = 3'd1;
  localparam logic [UOP_W-1:0] OP_MAC    = 3'd2;
  localparam logic [UOP_W-1:0] OP_CONST  = 3'd3;
  localparam logic [UOP_W-1:0] OP_FINISH = 3'd4;

  localparam logic [UCND_W-1:0] COND_NEVER    = 2'd0;
  localparam logic [UCND_W-1:0] COND_START    = 2'd1;
  localparam logic [UCND_W-1:0] COND_MORE     = 2'd2;
  localparam logic [UCND_W-1:0] COND_OUT_BUSY = 2'd3;

  // Jump to tgt when cond holds, else go to nxt
  typedef struct packed {
    logic [UOP_W-1:0]  op;
    logic [UCND_W-1:0] cond;
    logic [UPC_W-1:0]  tgt;
    logic [UPC_W-1:0]  nxt;
  } ucode_t;

  function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] upc);
    ucode_t w;
    unique case (upc)
      UC_IDLE:   w = '{op: OP_NONE,   cond: COND_START,    tgt: UC_INIT,   nxt: UC_IDLE};
      UC_INIT:   w = '{op: OP_INIT,   cond: COND_NEVER,    tgt: UC_IDLE,   nxt: UC_MAC};
      UC_MAC:    w = '{op: OP_MAC,    cond: COND_MORE,     tgt: UC_MAC,    nxt: UC_CONST};
      UC_CONST:  w = '{op: OP_CONST,  cond: COND_NEVER,    tgt: UC_IDLE,   nxt: UC_DRAIN0};
      UC_DRAIN0: w = '{op: OP_NONE,   cond: COND_NEVER,    tgt: UC_IDLE,   nxt: UC_DRAIN1};
      UC_DRAIN1: w = '{op: OP_NONE,   cond: COND_NEVER,    tgt: UC_IDLE,   nxt: UC_FINISH};
      UC_FINISH: w = '{op: OP_FINISH, cond: COND_OUT_BUSY, tgt: UC_FINISH, nxt: UC_IDLE};
      default:   w = '{op: OP_NONE,   cond: COND_NEVER,    tgt: UC_IDLE,   nxt: UC_IDLE};
    endcase
    return w;
  endfunction

endpackage

### hdl/var_process_generator_unit.sv
// ----------------------------------------------------------------------------
// var_process_generator_unit
// Multichannel VAR(p) generator: y = history * A + constant + noise, Q8.8.
// ----------------------------------------------------------------------------
// Load items (coefficient or history entry) leave the input open for the next
// item. A step item occupies the block from its accept to the next accept: a
// microcoded sequencer walks the LAG*DIM coefficient rows, plus the constant row
// when it is enabled, through the single row read port of the coefficient
// memory, one row per cycle into DIM parallel multiply-accumulators, followed
// by two pipeline drain steps and a finish step that rounds, saturates and
// writes the new sample into the history ring. The finish step waits while a
// previous result is still held on the output.
// History slots are relative to the newest sample (lag 0).
module var_process_generator_unit #(
  parameter int unsigned DIM = vpg_pkg::DIM_DEF,
  parameter int unsigned LAG = vpg_pkg::LAG_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic        [vpg_pkg::CMD_W-1:0]      cmd_i,
  input  logic        [vpg_pkg::SLOT_W-1:0]     slot_i,
  input  logic signed [vpg_pkg::DATA_W-1:0]     load_value_i,
  input  logic signed [vpg_pkg::DATA_W-1:0]     noise_0_i,
  input  logic signed [vpg_pkg::DATA_W-1:0]     noise_1_i,
  input  logic signed [vpg_pkg::DATA_W-1:0]     noise_2_i,
  input  logic signed [vpg_pkg::DATA_W-1:0]     noise_3_i,
  input  logic                                 cfg_we_i,
  input  logic        [vpg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic        [vpg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [vpg_pkg::DATA_W-1:0]     y_0_o,
  output logic signed [vpg_pkg::DATA_W-1:0]     y_1_o,
  output logic signed [vpg_pkg::DATA_W-1:0]     y_2_o,
  output logic signed [vpg_pkg::DATA_W-1:0]     y_3_o,
  output logic                                 clipped_o
);
  import vpg_pkg::*;

  localparam int unsigned HIST_DEPTH = LAG * DIM;
  localparam int unsigned NROWS      = HIST_DEPTH + 1;
  localparam int unsigned CONST_ROW  = HIST_DEPTH;
  localparam int unsigned COEF_DEPTH = NROWS * DIM;
  localparam int unsigned CH_W       = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int unsigned LAG_W      = (LAG > 1) ? $clog2(LAG) : 1;
  localparam int unsigned ROW_W      = $clog2(NROWS);
  localparam int unsigned PROD_W     = 2 * DATA_W;
  localparam int unsigned ACC_W      = PROD_W + $clog2(NROWS + 1) + 1;
  // slot / DIM by reciprocal multiply, then one correction step
  localparam int unsigned DIV_SH     = 9;
  localparam int unsigned RECIP      = ((1 << DIV_SH) + DIM - 1) / DIM;
  localparam int unsigned QP_W       = SLOT_W + DIV_SH + 1;
  localparam int unsigned BK_W       = SLOT_W + 3;

  // --------------------------------------------------------------------------
  // Handshake and sequencer
  // --------------------------------------------------------------------------
  logic [UPC_W-1:0] upc_q, upc_d;
  ucode_t           uc;
  logic             accept, step_acc, coef_acc, hist_acc;
  logic             out_vld_q, out_busy, fin, emit, cond_hit, row_last;
  logic             iss_mac, iss_vld;

  assign in_stall_o = (upc_q != UC_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign step_acc   = accept && (cmd_i == CMD_STEP);
  assign coef_acc   = accept && (cmd_i == CMD_LOAD_COEF);
  assign hist_acc   = accept && (cmd_i == CMD_LOAD_HIST);

  assign uc       = ucode_rom(upc_q);
  assign out_busy = out_vld_q && out_stall_i;
  assign fin      = (uc.op == OP_FINISH) && !out_busy;
  assign iss_mac  = (uc.op == OP_MAC);

  logic usec_q;
  assign iss_vld = iss_mac || ((uc.op == OP_CONST) && usec_q);

  logic [ROW_W-1:0] row_cnt_q;
  logic [LAG_W-1:0] lag_cnt_q;
  logic [CH_W-1:0]  ch_cnt_q;

  assign row_last = (row_cnt_q == ROW_W'(HIST_DEPTH - 1));

  always_comb begin
    unique case (uc.cond)
      COND_NEVER:    cond_hit = 1'b0;
      COND_START:    cond_hit = step_acc;
      COND_MORE:     cond_hit = !row_last;
      COND_OUT_BUSY: cond_hit = out_busy;
      default:       cond_hit = 1'b0;
    endcase
    upc_d = cond_hit ? uc.tgt : uc.nxt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q     <= UC_IDLE;
      row_cnt_q <= '0;
      lag_cnt_q <= '0;
      ch_cnt_q  <= '0;
    end else begin
      upc_q <= upc_d;
      if (uc.op == OP_INIT) begin
        row_cnt_q <= '0;
        lag_cnt_q <= '0;
        ch_cnt_q  <= '0;
      end else if (iss_mac) begin
        row_cnt_q <= row_cnt_q + ROW_W'(1);
        if (ch_cnt_q == CH_W'(DIM - 1)) begin
          ch_cnt_q  <= '0;
          lag_cnt_q <= lag_cnt_q + LAG_W'(1);
        end else begin
          ch_cnt_q <= ch_cnt_q + CH_W'(1);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Configuration and step count
  // --------------------------------------------------------------------------
  logic [CFG_DATA_W-1:0] burn_q;
  logic [DATA_W-1:0]     steps_q;
  logic [LAG_W-1:0]      head_q, head_d;

  assign emit   = (steps_q >= burn_q);
  assign head_d = (head_q == '0) ? LAG_W'(LAG - 1) : head_q - LAG_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burn_q  <= '0;
      usec_q  <= 1'b1;
      steps_q <= '0;
      head_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_BURN_IN:   burn_q <= cfg_data_i;
          CFG_USE_CONST: usec_q <= cfg_data_i[0];
          default:       ;
        endcase
      end
      if (fin) begin
        head_q <= head_d;
        if (steps_q != '1) steps_q <= steps_q + DATA_W'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Load address split: slot = row * DIM + lane
  // --------------------------------------------------------------------------
  logic [QP_W-1:0]   quo_prod;
  logic [SLOT_W-1:0] quo_est, quo;
  logic [BK_W-1:0]   back, rem;
  logic              over;
  logic [CH_W-1:0]   ld_ch;
  logic              coef_ok, hist_ok;

  always_comb begin
    quo_prod = QP_W'(slot_i) * QP_W'(RECIP);
    quo_est  = quo_prod[DIV_SH +: SLOT_W];
    back     = BK_W'(quo_est) * BK_W'(DIM);
    over     = back > BK_W'(slot_i);
    quo      = over ? quo_est - SLOT_W'(1) : quo_est;
    rem      = BK_W'(slot_i) - (over ? back - BK_W'(DIM) : back);
    ld_ch    = rem[CH_W-1:0];
    coef_ok  = 32'(slot_i) < 32'(COEF_DEPTH);
    hist_ok  = 32'(slot_i) < 32'(HIST_DEPTH);
  end

  function automatic logic [LAG_W-1:0] ring_idx(input logic [LAG_W-1:0] base,
                                                input logic [LAG_W-1:0] ofs);
    logic [LAG_W:0] sum;
    sum = {1'b0, base} + {1'b0, ofs};
    if (sum >= (LAG_W + 1)'(LAG)) sum = sum - (LAG_W + 1)'(LAG);
    return sum[LAG_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Coefficient memory: NROWS rows of DIM lanes
  // --------------------------------------------------------------------------
  logic [DIM-1:0][DATA_W-1:0] coef_mem [NROWS];
  logic [DIM-1:0][DATA_W-1:0] coef_rd_q;
  logic [ROW_W-1:0]           coef_raddr;

  assign coef_raddr = iss_mac ? row_cnt_q : ROW_W'(CONST_ROW);

  always_ff @(posedge clk_i) begin
    if (coef_acc && coef_ok) coef_mem[quo[ROW_W-1:0]][ld_ch] <= load_value_i;
    if (iss_vld) coef_rd_q <= coef_mem[coef_raddr];
  end

  // --------------------------------------------------------------------------
  // History ring: LAG rows of DIM lanes, lag 0 at head_q
  // --------------------------------------------------------------------------
  logic [DIM-1:0][DATA_W-1:0] hist_mem [LAG];
  logic [DIM-1:0][DATA_W-1:0] hist_rd_q;
  logic [DIM-1:0][DATA_W-1:0] hist_wdata;
  logic [DIM-1:0]             hist_we;
  logic [LAG_W-1:0]           hist_waddr, hist_raddr;
  logic signed [DATA_W-1:0]   y_sat [DIM];

  assign hist_raddr = ring_idx(head_q, lag_cnt_q);

  always_comb begin
    if (fin) begin
      hist_we    = '1;
      hist_waddr = head_d;
      for (int l = 0; l < DIM; l++) hist_wdata[l] = y_sat[l];
    end else begin
      hist_we    = (hist_acc && hist_ok) ? (DIM'(1) << ld_ch) : '0;
      hist_waddr = ring_idx(head_q, quo[LAG_W-1:0]);
      for (int l = 0; l < DIM; l++) hist_wdata[l] = load_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < DIM; l++) begin
      if (hist_we[l]) hist_mem[hist_waddr][l] <= hist_wdata[l];
    end
    if (iss_vld) hist_rd_q <= hist_mem[hist_raddr];
  end

  // --------------------------------------------------------------------------
  // MAC pipeline: read -> multiply -> accumulate
  // --------------------------------------------------------------------------
  logic                     rd_vld_q, rd_const_q, prod_vld_q;
  logic [CH_W-1:0]          rd_ch_q;
  logic signed [DATA_W-1:0] mac_x;
  logic signed [DATA_W-1:0] noise_in [NCH];
  logic signed [DATA_W-1:0] noise_q  [DIM];
  logic signed [PROD_W-1:0] prod_q   [DIM];
  logic signed [ACC_W-1:0]  acc_q    [DIM];

  assign noise_in[0] = noise_0_i;
  assign noise_in[1] = noise_1_i;
  assign noise_in[2] = noise_2_i;
  assign noise_in[3] = noise_3_i;

  assign mac_x = rd_const_q ? ONE_Q8 : $signed(hist_rd_q[rd_ch_q]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q   <= 1'b0;
      rd_const_q <= 1'b0;
      rd_ch_q    <= '0;
      prod_vld_q <= 1'b0;
    end else begin
      rd_vld_q   <= iss_vld;
      rd_const_q <= !iss_mac;
      rd_ch_q    <= ch_cnt_q;
      prod_vld_q <= rd_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < DIM; c++) begin
      if (step_acc) noise_q[c] <= noise_in[c];
      prod_q[c] <= mac_x * $signed(coef_rd_q[c]);
      if (uc.op == OP_INIT) begin
        acc_q[c] <= ACC_W'(noise_q[c]) <<< FRAC_SH;
      end else if (prod_vld_q) begin
        acc_q[c] <= acc_q[c] + ACC_W'(prod_q[c]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Round half up to Q8.8 and saturate
  // --------------------------------------------------------------------------
  logic signed [ACC_W-1:0]  rnd [DIM];
  logic signed [DATA_W-1:0] y_ext [NCH];
  logic                     clip_any;

  always_comb begin
    clip_any = 1'b0;
    for (int c = 0; c < DIM; c++) begin
      rnd[c] = (acc_q[c] + ACC_W'(ROUND_HALF)) >>> FRAC_SH;
      if (rnd[c] > ACC_W'(SAT_MAX)) begin
        y_sat[c] = DATA_W'(SAT_MAX);
        clip_any = 1'b1;
      end else if (rnd[c] < ACC_W'(SAT_MIN)) begin
        y_sat[c] = DATA_W'(SAT_MIN);
        clip_any = 1'b1;
      end else begin
        y_sat[c] = rnd[c][DATA_W-1:0];
      end
    end
    for (int c = 0; c < NCH; c++) y_ext[c] = '0;
    for (int c = 0; c < DIM; c++) y_ext[c] = y_sat[c];
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic signed [DATA_W-1:0] y_q [NCH];
  logic                     clip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      if (fin && emit) out_vld_q <= 1'b1;
      else if (out_vld_q && !out_stall_i) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin && emit) begin
      for (int c = 0; c < NCH; c++) y_q[c] <= y_ext[c];
      clip_q <= clip_any;
    end
  end

  assign out_valid_o = out_vld_q;
  assign y_0_o       = y_q[0];
  assign y_1_o       = y_q[1];
  assign y_2_o       = y_q[2];
  assign y_3_o       = y_q[3];
  assign clipped_o   = clip_q;

endmodule

### hdl/vpg_checker.sv
// ----------------------------------------------------------------------------
// vpg_checker
// Port-level checks of the VAR process generator, bound to the top level.
// ----------------------------------------------------------------------------
module vpg_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_stall_o,
  input logic        [vpg_pkg::CMD_W-1:0]      cmd_i,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic signed [vpg_pkg::DATA_W-1:0]     y_0_o,
  input logic signed [vpg_pkg::DATA_W-1:0]     y_1_o,
  input logic signed [vpg_pkg::DATA_W-1:0]     y_2_o,
  input logic signed [vpg_pkg::DATA_W-1:0]     y_3_o,
  input logic                                 clipped_o
);
  import vpg_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(y_0_o) && $stable(y_1_o)
      && $stable(y_2_o) && $stable(y_3_o) && $stable(clipped_o))
    else $error("result changed while stalled");

  // A step item starts the sequencer
  a_step_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (cmd_i == CMD_STEP) |=> in_stall_o)
    else $error("step item did not occupy the block");

  // Loads and unused commands leave the input open
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (cmd_i != CMD_STEP) |=> !in_stall_o)
    else $error("load item stalled the input");

  // A new result only appears at the end of a running step
  a_out_from_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a step in progress");

endmodule

bind var_process_generator_unit vpg_checker u_vpg_checker (.*);
